>>> hw/rtl/instance_normalization_core_macros.svh
// Assertion helpers used by instance_normalization_core.
`ifndef INSTANCE_NORMALIZATION_CORE_MACROS_SVH
`define INSTANCE_NORMALIZATION_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk_i, quiet during reset.
`define INORM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, clocked on clk_i, quiet during reset.
`define INORM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/inorm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package inorm_pkg;

  localparam int unsigned CNT_W   = 7;   // slice length counter, up to 64
  localparam int unsigned SUMSQ_W = 37;
  localparam int unsigned DIVD_W  = 43;  // divider dividend / quotient
  localparam int unsigned DVS_W   = 31;  // divider divisor
  localparam int unsigned SQ_W    = 48;  // square root working width
  localparam int unsigned MA_W    = 38;  // multiplier operand a
  localparam int unsigned MB_W    = 24;  // multiplier operand b
  localparam int unsigned PROD_W  = MA_W + MB_W;

  localparam logic REG_EPSILON = 1'b0;   // register index, paddr[2]

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_ADDR,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_V_NSQ,
    ST_V_SS,
    ST_V_NN,
    ST_V_LD,
    ST_VDIV,
    ST_SQ_INIT,
    ST_SQRT,
    ST_DEN,
    ST_DEN_LD,
    ST_E_ADDR,
    ST_E_MUL1,
    ST_E_SUB,
    ST_E_MUL2,
    ST_E_MAG,
    ST_EDIV,
    ST_E_OUT
  } state_e;

endpackage
`default_nettype wire

>>> hw/rtl/inorm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module inorm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> hw/rtl/instance_normalization_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Instance normalization over one slice of Q8.8 samples.
// Input channel (valid/ready): one sample per item, with the channel's Q4.12
// scale and Q8.8 bias; slice_end_i flags the last sample. A slice also ends
// when it reaches MAX_SLICE samples. Samples are taken one per cycle while idle.
// After the ending item the block is busy: a sum-of-squares pass, variance
// division, a 24-step square root and setup steps. Each result is then
// formed by the 43-step restoring divider that produces the quotient.
// Results leave through an output register (valid/ready): normalized_o,
// with result_last_o on the slice's final item. A stalled receiver holds the
// output register and the emission pass waits for it; the block takes the
// next slice's first item as soon as the last result is loaded.
// Configuration: APB-style port, epsilon (unsigned Q0.16) at address 0. The user
// must write it only while idle; the block does not check. pready is always high.
// Reset: sequencer idle, no output item pending, running sum and count at
// zero, epsilon at 1. The sample store needs no clearing.
module instance_normalization_core #(
  parameter int unsigned MAX_SLICE = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic signed [15:0] sample_i,
  input  wire logic signed [15:0] channel_scale_i,
  input  wire logic signed [15:0] channel_bias_i,
  input  wire logic               slice_end_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic signed [15:0]      normalized_o,
  output logic                    result_last_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int unsigned AW = (MAX_SLICE > 1) ? $clog2(MAX_SLICE) : 1;
  localparam int unsigned CW = inorm_pkg::CNT_W;

  inorm_pkg::state_e state_q, state_d;

  // Configuration
  logic [15:0] eps_q;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == inorm_pkg::REG_EPSILON) ? {16'b0, eps_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= 16'd1;
    end else if (psel && penable && pwrite && (paddr[2] == inorm_pkg::REG_EPSILON)) begin
      eps_q <= pwdata[15:0];
    end
  end

  // Control and datapath registers
  logic [CW-1:0]  cnt_q, cnt_d;        // fill count
  logic [22:0]    sum_q, sum_d;        // running sum
  logic [CW-1:0]  n_q, n_d;            // slice length
  logic [CW-1:0]  i_q, i_d;            // pass index
  logic [5:0]     step_q, step_d;      // divider / square root step
  logic signed [15:0] scale_q, scale_d, bias_q, bias_d;
  logic [inorm_pkg::SUMSQ_W-1:0] sumsq_q, sumsq_d;
  logic [42:0]    t1_q, t1_d, d_q, d_d;
  logic [inorm_pkg::DVS_W-1:0]  dvs_q, dvs_d, den_q, den_d;
  logic [inorm_pkg::DVS_W-1:0]  rem_q, rem_d;
  logic [inorm_pkg::DIVD_W-1:0] quo_q, quo_d;
  logic [inorm_pkg::SQ_W-1:0]   srem_q, srem_d, sres_q, sres_d, sbit_q, sbit_d;
  logic signed [23:0] diff_q, diff_d;
  logic           neg_q, neg_d;
  logic signed [15:0] y_q, y_d;
  logic           last_q, last_d;
  logic           ovalid_q, ovalid_d;

  // Shared multiplier, registered
  logic signed [inorm_pkg::MA_W-1:0]   mul_a;
  logic signed [inorm_pkg::MB_W-1:0]   mul_b;
  logic signed [inorm_pkg::PROD_W-1:0] prod_q;

  // Sample store
  logic signed [15:0] rdata;
  logic               we;

  inorm_ram #(.WIDTH(16), .DEPTH(MAX_SLICE)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (sample_i),
    .raddr_i (i_q[AW-1:0]),
    .rdata_o (rdata)
  );

  logic accept, ends, slot_free, div_last, sq_last, pass_last;
  logic [CW-1:0] cnt_inc;

  assign in_ready_o = (state_q == inorm_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign cnt_inc    = cnt_q + CW'(1);
  assign ends       = slice_end_i || (cnt_inc == CW'(MAX_SLICE));
  assign we         = accept;
  assign slot_free  = !ovalid_q || out_ready_i;
  assign div_last   = (step_q == 6'(inorm_pkg::DIVD_W - 1));
  assign sq_last    = (step_q == 6'd23);
  assign pass_last  = (i_q + CW'(1) == n_q);

  // Divider and square root step logic
  logic [inorm_pkg::DVS_W:0] trial;
  logic                      div_ge;
  logic [inorm_pkg::SQ_W-1:0] sq_try;
  logic                      sq_ge;
  logic signed [43:0]        dd;
  logic [31:0]               v;
  logic [23:0]               r;
  logic [41:0]               mag;
  logic signed [17:0]        ysum;

  assign trial  = {rem_q, quo_q[inorm_pkg::DIVD_W-1]};
  assign div_ge = (trial >= {1'b0, dvs_q});
  assign sq_try = sres_q + sbit_q;
  assign sq_ge  = (srem_q >= sq_try);
  assign dd     = $signed({1'b0, t1_q}) - $signed({1'b0, prod_q[42:0]});
  assign v      = {1'b0, quo_q[30:0]} + {16'b0, eps_q};
  assign r      = (sres_q[23:0] == 24'd0) ? 24'd1 : sres_q[23:0];
  assign mag    = prod_q[inorm_pkg::PROD_W-1] ? 42'(-prod_q) << 4 : 42'(prod_q) << 4;
  assign ysum   = neg_q ? 18'(bias_q) - $signed({2'b0, quo_q[15:0]})
                        : 18'(bias_q) + $signed({2'b0, quo_q[15:0]});

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      inorm_pkg::ST_IDLE:    if (accept && ends) state_d = inorm_pkg::ST_SQ_ADDR;
      inorm_pkg::ST_SQ_ADDR: state_d = inorm_pkg::ST_SQ_MUL;
      inorm_pkg::ST_SQ_MUL:  state_d = inorm_pkg::ST_SQ_ACC;
      inorm_pkg::ST_SQ_ACC:  state_d = pass_last ? inorm_pkg::ST_V_NSQ : inorm_pkg::ST_SQ_ADDR;
      inorm_pkg::ST_V_NSQ:   state_d = inorm_pkg::ST_V_SS;
      inorm_pkg::ST_V_SS:    state_d = inorm_pkg::ST_V_NN;
      inorm_pkg::ST_V_NN:    state_d = inorm_pkg::ST_V_LD;
      inorm_pkg::ST_V_LD:    state_d = inorm_pkg::ST_VDIV;
      inorm_pkg::ST_VDIV:    if (div_last) state_d = inorm_pkg::ST_SQ_INIT;
      inorm_pkg::ST_SQ_INIT: state_d = inorm_pkg::ST_SQRT;
      inorm_pkg::ST_SQRT:    if (sq_last) state_d = inorm_pkg::ST_DEN;
      inorm_pkg::ST_DEN:     state_d = inorm_pkg::ST_DEN_LD;
      inorm_pkg::ST_DEN_LD:  state_d = inorm_pkg::ST_E_ADDR;
      inorm_pkg::ST_E_ADDR:  state_d = inorm_pkg::ST_E_MUL1;
      inorm_pkg::ST_E_MUL1:  state_d = inorm_pkg::ST_E_SUB;
      inorm_pkg::ST_E_SUB:   state_d = inorm_pkg::ST_E_MUL2;
      inorm_pkg::ST_E_MUL2:  state_d = inorm_pkg::ST_E_MAG;
      inorm_pkg::ST_E_MAG:   state_d = inorm_pkg::ST_EDIV;
      inorm_pkg::ST_EDIV:    if (div_last) state_d = inorm_pkg::ST_E_OUT;
      inorm_pkg::ST_E_OUT: begin
        if (slot_free) state_d = pass_last ? inorm_pkg::ST_IDLE : inorm_pkg::ST_E_ADDR;
      end
      default:               state_d = inorm_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    cnt_d = cnt_q;  sum_d = sum_q;  n_d = n_q;  i_d = i_q;  step_d = step_q;
    scale_d = scale_q;  bias_d = bias_q;  sumsq_d = sumsq_q;
    t1_d = t1_q;  d_d = d_q;  dvs_d = dvs_q;  den_d = den_q;
    rem_d = rem_q;  quo_d = quo_q;
    srem_d = srem_q;  sres_d = sres_q;  sbit_d = sbit_q;
    diff_d = diff_q;  neg_d = neg_q;  y_d = y_q;  last_d = last_q;
    ovalid_d = ovalid_q && !out_ready_i;
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      inorm_pkg::ST_IDLE: begin
        if (accept) begin
          cnt_d = cnt_inc;
          sum_d = sum_q + 23'(sample_i);
          if (ends) begin
            n_d = cnt_inc;  scale_d = channel_scale_i;  bias_d = channel_bias_i;
            i_d = '0;  sumsq_d = '0;
          end
        end
      end
      inorm_pkg::ST_SQ_MUL: begin
        mul_a = 38'(rdata);
        mul_b = 24'(rdata);
      end
      inorm_pkg::ST_SQ_ACC: begin
        sumsq_d = sumsq_q + prod_q[inorm_pkg::SUMSQ_W-1:0];
        i_d = i_q + CW'(1);
      end
      inorm_pkg::ST_V_NSQ: begin
        mul_a = $signed({1'b0, sumsq_q});
        mul_b = $signed({17'b0, n_q});
      end
      inorm_pkg::ST_V_SS: begin
        t1_d  = prod_q[42:0];
        mul_a = 38'($signed(sum_q));
        mul_b = 24'($signed(sum_q));
      end
      inorm_pkg::ST_V_NN: begin
        d_d   = dd[43] ? 43'd0 : dd[42:0];
        mul_a = $signed({31'b0, n_q});
        mul_b = $signed({17'b0, n_q});
      end
      inorm_pkg::ST_V_LD: begin
        quo_d = d_q;  rem_d = '0;  dvs_d = prod_q[inorm_pkg::DVS_W-1:0];  step_d = '0;
      end
      inorm_pkg::ST_VDIV, inorm_pkg::ST_EDIV: begin
        rem_d  = div_ge ? inorm_pkg::DVS_W'(trial - {1'b0, dvs_q})
                        : trial[inorm_pkg::DVS_W-1:0];
        quo_d  = {quo_q[inorm_pkg::DIVD_W-2:0], div_ge};
        step_d = step_q + 6'd1;
      end
      inorm_pkg::ST_SQ_INIT: begin
        srem_d = {v[31:0], 16'b0};
        sres_d = '0;
        sbit_d = inorm_pkg::SQ_W'(1) << 46;
        step_d = '0;
      end
      inorm_pkg::ST_SQRT: begin
        if (sq_ge) begin
          srem_d = srem_q - sq_try;
          sres_d = (sres_q >> 1) + sbit_q;
        end else begin
          sres_d = sres_q >> 1;
        end
        sbit_d = sbit_q >> 2;
        step_d = step_q + 6'd1;
      end
      inorm_pkg::ST_DEN: begin
        mul_a = $signed({14'b0, r});
        mul_b = $signed({17'b0, n_q});
        i_d   = '0;
      end
      inorm_pkg::ST_DEN_LD: begin
        den_d = prod_q[inorm_pkg::DVS_W-1:0];
      end
      inorm_pkg::ST_E_MUL1: begin
        mul_a = 38'(rdata);
        mul_b = $signed({17'b0, n_q});
      end
      inorm_pkg::ST_E_SUB: begin
        diff_d = prod_q[23:0] - 24'($signed(sum_q));
      end
      inorm_pkg::ST_E_MUL2: begin
        mul_a = 38'(diff_q);
        mul_b = 24'(scale_q);
      end
      inorm_pkg::ST_E_MAG: begin
        neg_d  = prod_q[inorm_pkg::PROD_W-1];
        quo_d  = {1'b0, mag} + {12'b0, den_q >> 1};
        rem_d  = '0;
        dvs_d  = den_q;
        step_d = '0;
      end
      inorm_pkg::ST_E_OUT: begin
        if (slot_free) begin
          // saturate the quotient before adding it to the bias
          if (quo_q > 43'd65535) begin
            y_d = neg_q ? -16'sd32768 : 16'sd32767;
          end else if (ysum > 18'sd32767) begin
            y_d = 16'sd32767;
          end else if (ysum < -18'sd32768) begin
            y_d = -16'sd32768;
          end else begin
            y_d = ysum[15:0];
          end
          last_d   = pass_last;
          ovalid_d = 1'b1;
          i_d      = i_q + CW'(1);
          if (pass_last) begin
            sum_d = '0;
            cnt_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= inorm_pkg::ST_IDLE;
      cnt_q    <= '0;
      sum_q    <= '0;
      ovalid_q <= 1'b0;
      i_q      <= '0;
      step_q   <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      sum_q    <= sum_d;
      ovalid_q <= ovalid_d;
      i_q      <= i_d;
      step_q   <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= mul_a * mul_b;
    n_q     <= n_d;      scale_q <= scale_d;  bias_q <= bias_d;
    sumsq_q <= sumsq_d;  t1_q    <= t1_d;     d_q    <= d_d;
    dvs_q   <= dvs_d;    den_q   <= den_d;
    rem_q   <= rem_d;    quo_q   <= quo_d;
    srem_q  <= srem_d;   sres_q  <= sres_d;   sbit_q <= sbit_d;
    diff_q  <= diff_d;   neg_q   <= neg_d;
    y_q     <= y_d;      last_q  <= last_d;
  end

  assign normalized_o  = y_q;
  assign result_last_o = last_q;
  assign out_valid_o   = ovalid_q;

`include "instance_normalization_core_macros.svh"

  // the divider remainder stays below the divisor
  `INORM_ASSERT_NOW(a_div_rem, (state_q == inorm_pkg::ST_VDIV || state_q == inorm_pkg::ST_EDIV), rem_q < dvs_q)
  // the square root probe bit is a single bit or spent
  `INORM_ASSERT_NOW(a_sq_bit, state_q == inorm_pkg::ST_SQRT, $onehot0(sbit_q))
  // loading the final result returns the sequencer to idle with an empty slice
  `INORM_ASSERT_NEXT(a_last_idle, (state_q == inorm_pkg::ST_E_OUT && slot_free && pass_last), (state_q == inorm_pkg::ST_IDLE && cnt_q == '0 && out_valid_o && result_last_o))

endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int unsigned SLICE_MAX = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic signed [15:0] sample_i = '0;
  logic signed [15:0] channel_scale_i = '0;
  logic signed [15:0] channel_bias_i = '0;
  logic slice_end_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] normalized_o;
  logic result_last_o;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  instance_normalization_core #(.MAX_SLICE(SLICE_MAX)) dut (.*);

  // Expected normalized outputs, oldest first.
  typedef struct packed {
    logic signed [15:0] value;
    logic last;
  } norm_result_t;
  norm_result_t expected_q[$];

  // Predictor state: stored slice samples, running sum, count, epsilon.
  logic signed [15:0] slice_buf [SLICE_MAX];
  int slice_sum;
  int slice_len;
  logic [15:0] eps_reg;

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int slices_done = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("tb: FAIL");
    $finish;
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // Bit-exact floor(sqrt(a)), 24 steps.
  function automatic longint unsigned sqrt_floor(input longint unsigned a);
    longint unsigned rem, res, bitv;
    rem = a;
    res = 0;
    bitv = 64'd1 << 46;
    for (int k = 0; k < 24; k++) begin
      if (rem >= res + bitv) begin
        rem -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Accept one sample; on a slice end, queue the normalized slice.
  task automatic predict_slice(input logic signed [15:0] x, input logic signed [15:0] sc,
                               input logic signed [15:0] bs, input logic fin);
    longint n, sumsq, d, s, num, y;
    longint unsigned var_q, r, den, mag, q;
    norm_result_t res;
    slice_buf[slice_len] = x;
    slice_sum += x;
    slice_len++;
    if (!fin && slice_len < SLICE_MAX) return;
    n = slice_len;
    sumsq = 0;
    for (int i = 0; i < n; i++) begin
      s = slice_buf[i];
      sumsq += s * s;
    end
    d = n * sumsq - longint'(slice_sum) * slice_sum;
    if (d < 0) d = 0;
    var_q = longint'(d) / (n * n);
    r = sqrt_floor((var_q + eps_reg) << 16);
    if (r == 0) r = 1;
    den = n * r;
    for (int i = 0; i < n; i++) begin
      s = slice_buf[i];
      num = (n * s - slice_sum) * longint'(sc) * 16;
      mag = num < 0 ? -num : num;
      q = (mag + den / 2) / den;
      y = num < 0 ? longint'(bs) - longint'(q) : longint'(bs) + longint'(q);
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      res.value = y[15:0];
      res.last = (i == n - 1);
      expected_q.push_back(res);
    end
    slice_sum = 0;
    slice_len = 0;
    slices_done++;
  endtask

  // Send one item; idle randomly first, then hold until accepted.
  // Valid stays high after acceptance unless the sender idles or drains.
  task automatic send_item(input logic signed [15:0] x, input logic signed [15:0] sc,
                           input logic signed [15:0] bs, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    sample_i <= x;
    channel_scale_i <= sc;
    channel_bias_i <= bs;
    slice_end_i <= fin;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_slice(x, sc, bs, fin);
    items_sent++;
  endtask

  // Drain: wait for every queued result, then let the block settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_epsilon(input logic [15:0] value);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {inorm_pkg::REG_EPSILON, 2'b00};
    pwdata <= {16'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    eps_reg = value;
  endtask

  // Send a whole slice of random samples around a random center.
  task automatic send_random_slice(input int len);
    logic signed [15:0] sc, bs, ctr, x;
    int spread;
    sc = 16'($urandom);
    bs = 16'($urandom);
    ctr = 16'($urandom);
    spread = 1 << $urandom_range(15);
    for (int i = 0; i < len; i++) begin
      x = ($urandom_range(3) == 0) ? 16'($urandom) : ctr + 16'($urandom_range(spread));
      send_item(x, sc, bs, i == len - 1);
    end
  endtask

  task automatic test_directed();
    // Single-sample slice: zero variance, default epsilon.
    send_item(16'sh1234, 16'sh1000, 16'sh0100, 1'b1);
    // Extremes of every field.
    send_item(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
    send_item(-16'sh8000, 16'sh7fff, 16'sh7fff, 1'b0);
    send_item(16'sh0000, -16'sh8000, -16'sh8000, 1'b1);
    send_item(-16'sh8000, -16'sh8000, -16'sh8000, 1'b0);
    send_item(16'sh7fff, -16'sh8000, 16'sh0000, 1'b1);
    send_item(16'shffff, 16'shffff, 16'shffff, 1'b0);
    send_item(16'sh5555, 16'shaaaa, 16'sh5555, 1'b1);
  endtask

  task automatic test_zero_epsilon();
    // Zero variance with zero epsilon: every output of the first slice equals bias.
    write_epsilon(16'h0000);
    for (int i = 0; i < 4; i++) send_item(16'sh0200, 16'sh1000, 16'sh0042, i == 3);
    send_item(16'sh0001, 16'sh7fff, 16'sh0000, 1'b0);
    send_item(16'sh0002, 16'sh7fff, 16'sh0000, 1'b1);
  endtask

  task automatic test_full_store();
    // A full store ends the slice without slice_end.
    write_epsilon(16'hffff);
    for (int i = 0; i < SLICE_MAX; i++) send_item(16'($urandom), 16'sh1000, 16'sh0010, 1'b0);
    send_item(16'sh0100, 16'sh1000, 16'sh0000, 1'b1);
  endtask

  task automatic test_random(input int count, input int sidle, input int ridle);
    int start;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(15) == 0) send_random_slice($urandom_range(40, SLICE_MAX));
      else send_random_slice($urandom_range(1, 8));
    end
  endtask

  task automatic test_pause();
    // Hold the sender until every result is back.
    send_random_slice(3);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    send_random_slice(2);
  endtask

  // Receiver: random stalls, compare each result with the oldest expectation.
  always @(posedge clk_i) begin
    norm_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report("result with nothing expected");
        end else begin
          want = expected_q.pop_front();
          if (normalized_o !== want.value)
            report($sformatf("normalized %0d, expected %0d", normalized_o, want.value));
          if (result_last_o !== want.last)
            report($sformatf("result_last %b, expected %b", result_last_o, want.last));
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    slice_sum = 0;
    slice_len = 0;
    eps_reg = 16'd1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_zero_epsilon();
    test_full_store();
    write_epsilon(16'h0100);
    test_random(120, 37, 83);
    test_pause();
    write_epsilon(16'($urandom));
    test_random(120, 83, 37);
    write_epsilon(16'h0001);
    test_random(120, 0, 0);
    wait_drained();
    $display("covered %0d items in %0d slices, %0d results checked",
             items_sent, slices_done, results_seen);
    $display("epsilon swept over zero, one, full scale and random values");
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
